// File: sv/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

  localparam int unsigned LenW = 63;
  localparam int unsigned KeyW = 32;

  localparam logic [6:0] LenExt16 = 7'd126;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              fin;
    logic [3:0]        opcode;
    logic              masked;
    logic [LenW-1:0]   length;
    logic [7:0]        data;
    logic              last;
  } wsfd_res_t;

endpackage

`default_nettype wire

// File: sv/wsfd_parser.sv
// ----------------------------------------------------------------------------
// wsfd_parser
// Frame parser state and per-byte decode: header fields, extended length,
// mask key capture and payload unmasking.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfd_parser import wsfd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [7:0] byte_i,
  input  wire logic      step_en,
  output logic           res_vld,
  output wsfd_res_t      res
);

  phase_t            phase_r, phase_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              long_r, long_nxt;
  logic [LenW-1:0]   len_r, len_nxt;
  logic [KeyW-1:0]   key_r, key_nxt;
  logic              fin_r, fin_nxt;
  logic [3:0]        op_r, op_nxt;
  logic              masked_r, masked_nxt;
  logic [LenW-1:0]   rem_r, rem_nxt;
  logic [1:0]        idx_r, idx_nxt;

  logic              len_done;
  logic              hdr_done;
  logic [7:0]        key_byte;

  always_comb begin
    case (idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    long_nxt   = long_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    fin_nxt    = fin_r;
    op_nxt     = op_r;
    masked_nxt = masked_r;
    rem_nxt    = rem_r;
    idx_nxt    = idx_r;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    res_vld    = 1'b0;
    res.kind   = KIND_HEADER;
    res.data   = 8'd0;
    res.last   = 1'b0;

    case (phase_r)
      PH_HDR1: begin
        masked_nxt = byte_i[7];
        key_nxt    = '0;
        cnt_nxt    = 3'd0;
        if (byte_i[6:0] < LenExt16) begin
          len_nxt  = {{(LenW-7){1'b0}}, byte_i[6:0]};
          long_nxt = 1'b0;
          len_done = 1'b1;
        end else begin
          len_nxt   = '0;
          long_nxt  = (byte_i[6:0] != LenExt16);
          phase_nxt = PH_EXT;
        end
      end
      PH_EXT: begin
        len_nxt = {len_r[LenW-9:0], byte_i};
        if (long_r ? (cnt_r == 3'd7) : (cnt_r == 3'd1)) begin
          len_done = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[KeyW-9:0], byte_i};
        if (cnt_r >= 3'd3) begin
          hdr_done = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      PH_DATA: begin
        res_vld  = 1'b1;
        res.kind = KIND_PAYLOAD;
        res.data = byte_i ^ key_byte;
        idx_nxt  = idx_r + 2'd1;
        rem_nxt  = rem_r - {{(LenW-1){1'b0}}, 1'b1};
        if (rem_r <= {{(LenW-1){1'b0}}, 1'b1}) begin
          res.last  = 1'b1;
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        fin_nxt   = byte_i[7];
        op_nxt    = byte_i[3:0];
        cnt_nxt   = 3'd0;
        phase_nxt = PH_HDR1;
      end
    endcase

    if (len_done) begin
      cnt_nxt = 3'd0;
      if (masked_nxt) begin
        phase_nxt = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      cnt_nxt  = 3'd0;
      rem_nxt  = len_nxt;
      idx_nxt  = 2'd0;
      res_vld  = 1'b1;
      res.last = (len_nxt == '0);
      phase_nxt = (len_nxt == '0) ? PH_HDR0 : PH_DATA;
    end

    res.fin    = fin_nxt;
    res.opcode = op_nxt;
    res.masked = masked_nxt;
    res.length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      cnt_r    <= 3'd0;
      long_r   <= 1'b0;
      len_r    <= '0;
      key_r    <= '0;
      fin_r    <= 1'b0;
      op_r     <= 4'd0;
      masked_r <= 1'b0;
      rem_r    <= '0;
      idx_r    <= 2'd0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      long_r   <= long_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      fin_r    <= fin_nxt;
      op_r     <= op_nxt;
      masked_r <= masked_nxt;
      rem_r    <= rem_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/websocket_frame_deframer.sv
// Datapath: a byte taken into s1_byte_r is decoded by wsfd_parser and, if it
//   yields a result, the result is registered in out_res_r with out_valid set.
// Throughput: one byte per clock, limited only by out_ready back-pressure.
// Reset: synchronous, active-low rst_n; parser returns to the first header
//   byte and both pipeline stages empty.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// WebSocket receive-side deframer: header decode, mask key capture and
// payload unmasking on a byte stream, one header result per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer import wsfd_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_result_kind,
  output logic                 out_fin_flag,
  output logic [3:0]           out_opcode,
  output logic                 out_masked_flag,
  output logic [LenW-1:0]      out_payload_length,
  output logic [7:0]           out_data_byte,
  output logic                 out_last_flag
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  wsfd_res_t  out_res_r;

  logic       res_vld;
  wsfd_res_t  res;
  logic       out_free;
  logic       s1_adv;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!res_vld || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  wsfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_i  (s1_byte_r),
    .step_en (s1_adv),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_res_r.kind;
  assign out_fin_flag       = out_res_r.fin;
  assign out_opcode         = out_res_r.opcode;
  assign out_masked_flag    = out_res_r.masked;
  assign out_payload_length = out_res_r.length;
  assign out_data_byte      = out_res_r.data;
  assign out_last_flag      = out_res_r.last;

endmodule

`default_nettype wire

// File: sv/wsfd_checker.sv
// ----------------------------------------------------------------------------
// wsfd_checker
// Port-level assertions for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfd_checker import wsfd_pkg::*; (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic            out_result_kind,
  input wire logic [LenW-1:0] out_payload_length,
  input wire logic [7:0]      out_data_byte,
  input wire logic            out_last_flag
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data_byte) && $stable(out_last_flag)
      && $stable(out_result_kind) && $stable(out_payload_length))
    else $error("result changed while stalled");

  a_hdr_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_HEADER) |-> out_data_byte == 8'd0)
    else $error("header result carries data");

  a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_HEADER)
      |-> out_last_flag == (out_payload_length == '0))
    else $error("header last flag disagrees with length");

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_kind    (out_result_kind),
  .out_payload_length (out_payload_length),
  .out_data_byte      (out_data_byte),
  .out_last_flag      (out_last_flag)
);

`default_nettype wire

// File: test/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Feeds WebSocket frame streams into the deframer one byte per transfer and
// checks every header and payload result against a cycle-free parser model.
// A short directed table covers empty frames, extended lengths with the
// reserved top bit set and non-minimal encodings; random frames follow,
// under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------

module websocket_frame_deframer_tb;
  import wsfd_pkg::*;

  localparam logic [6:0] LenExt64   = 7'd127;
  localparam int         StallLimit = 4000;
  localparam int         PhaseBytes = 433;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    wsfd_res_t  res;
  } stim_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      in_byte = 8'h00;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            out_result_kind;
  logic            out_fin_flag;
  logic [3:0]      out_opcode;
  logic            out_masked_flag;
  logic [LenW-1:0] out_payload_length;
  logic [7:0]      out_data_byte;
  logic            out_last_flag;

  websocket_frame_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_fin_flag      (out_fin_flag),
    .out_opcode        (out_opcode),
    .out_masked_flag   (out_masked_flag),
    .out_payload_length(out_payload_length),
    .out_data_byte     (out_data_byte),
    .out_last_flag     (out_last_flag)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Parser state mirrored from the block
  phase_t          prs_phase = PH_HDR0;
  logic [2:0]      prs_field_cnt = '0;
  logic [3:0]      prs_ext_bytes = '0;
  logic [63:0]     prs_length = '0;
  logic [KeyW-1:0] prs_key = '0;
  logic            prs_fin = 1'b0;
  logic [3:0]      prs_opcode = '0;
  logic            prs_masked = 1'b0;
  logic [63:0]     prs_count = '0;

  wsfd_res_t due_results[$];
  int        fail_count = 0;
  int        stall_cycles = 0;
  int        send_idle = 0;
  int        recv_idle = 0;
  int        phase_bytes = 0;
  int        send_idle_plan[3] = '{19, 79, 0};
  int        recv_idle_plan[3] = '{79, 19, 0};
  bit        drv_typed = 1'b0;
  wsfd_res_t drv_res = '0;
  stim_row_t dir_rows[$];

  function automatic wsfd_res_t pack_result(kind_t kind, logic [7:0] data, logic last);
    wsfd_res_t r;
    r.kind   = kind;
    r.fin    = prs_fin;
    r.opcode = prs_opcode;
    r.masked = prs_masked;
    r.length = prs_length[LenW-1:0];
    r.data   = data;
    r.last   = last;
    return r;
  endfunction

  function automatic bit close_header(output wsfd_res_t res);
    prs_length[63] = 1'b0;
    prs_count      = '0;
    prs_field_cnt  = '0;
    res = pack_result(KIND_HEADER, 8'h00, prs_length == 64'd0);
    prs_phase = (prs_length == 64'd0) ? PH_HDR0 : PH_DATA;
    return 1'b1;
  endfunction

  function automatic bit after_length(output wsfd_res_t res);
    res = '0;
    prs_field_cnt = '0;
    if (prs_masked) begin
      prs_phase = PH_KEY;
      return 1'b0;
    end
    return close_header(res);
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output wsfd_res_t res);
    logic [7:0] key_byte;
    res = '0;
    case (prs_phase)
      PH_HDR1: begin
        prs_masked    = b[7];
        prs_key       = '0;
        prs_length    = '0;
        prs_field_cnt = '0;
        if (b[6:0] < LenExt16) begin
          prs_length    = 64'(b[6:0]);
          prs_ext_bytes = '0;
          return after_length(res);
        end
        prs_ext_bytes = (b[6:0] == LenExt16) ? 4'd2 : 4'd8;
        prs_phase = PH_EXT;
        return 1'b0;
      end
      PH_EXT: begin
        prs_length = {prs_length[55:0], b};
        if ({1'b0, prs_field_cnt} + 4'd1 >= prs_ext_bytes) begin
          prs_length[63] = 1'b0;
          return after_length(res);
        end
        prs_field_cnt = prs_field_cnt + 3'd1;
        return 1'b0;
      end
      PH_KEY: begin
        prs_key = {prs_key[23:0], b};
        if (prs_field_cnt >= 3'd3) return close_header(res);
        prs_field_cnt = prs_field_cnt + 3'd1;
        return 1'b0;
      end
      PH_DATA: begin
        key_byte  = prs_masked ? 8'(prs_key >> {~prs_count[1:0], 3'b000}) : 8'h00;
        prs_count = prs_count + 64'd1;
        res = pack_result(KIND_PAYLOAD, b ^ key_byte, prs_count >= prs_length);
        if (prs_count >= prs_length) begin
          prs_phase = PH_HDR0;
          prs_count = '0;
        end
        return 1'b1;
      end
      default: begin
        prs_fin       = b[7];
        prs_opcode    = b[3:0];
        prs_field_cnt = '0;
        prs_phase     = PH_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic stim_row_t plain_row(logic [7:0] b);
    stim_row_t r;
    r.b     = b;
    r.typed = 1'b0;
    r.res   = '0;
    return r;
  endfunction

  function automatic stim_row_t checked_row(logic [7:0] b, kind_t kind, logic fin,
                                            logic [3:0] opc, logic masked,
                                            logic [LenW-1:0] len, logic [7:0] data,
                                            logic last);
    stim_row_t r;
    r.b          = b;
    r.typed      = 1'b1;
    r.res.kind   = kind;
    r.res.fin    = fin;
    r.res.opcode = opc;
    r.res.masked = masked;
    r.res.length = len;
    r.res.data   = data;
    r.res.last   = last;
    return r;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    wsfd_res_t exp_res;
    wsfd_res_t got_res;
    bit        produced;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d data %02h", out_result_kind, out_data_byte);
          fail_count++;
        end else begin
          exp_res = due_results.pop_front();
          if (out_result_kind !== exp_res.kind) begin
            $error("result_kind: expected %0d, got %0d", exp_res.kind, out_result_kind);
            fail_count++;
          end
          if (out_fin_flag !== exp_res.fin) begin
            $error("fin_flag: expected %0d, got %0d", exp_res.fin, out_fin_flag);
            fail_count++;
          end
          if (out_opcode !== exp_res.opcode) begin
            $error("opcode: expected %0d, got %0d", exp_res.opcode, out_opcode);
            fail_count++;
          end
          if (out_masked_flag !== exp_res.masked) begin
            $error("masked_flag: expected %0d, got %0d", exp_res.masked, out_masked_flag);
            fail_count++;
          end
          if (out_payload_length !== exp_res.length) begin
            $error("payload_length: expected %0d, got %0d", exp_res.length,
                   out_payload_length);
            fail_count++;
          end
          if (out_data_byte !== exp_res.data) begin
            $error("data_byte: expected %02h, got %02h", exp_res.data, out_data_byte);
            fail_count++;
          end
          if (out_last_flag !== exp_res.last) begin
            $error("last_flag: expected %0d, got %0d", exp_res.last, out_last_flag);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        produced = deframe_byte(in_byte, got_res);
        if (drv_typed) due_results.push_back(drv_res);
        else if (produced) due_results.push_back(got_res);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("websocket_frame_deframer test failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit typed, input wsfd_res_t res);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    drv_typed = typed;
    drv_res   = res;
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_frame();
    logic [7:0]  fq[$];
    int          pick;
    int unsigned len;
    logic        msk;
    logic [31:0] key;
    pick = $urandom_range(99);
    msk  = 1'($urandom_range(1));
    key  = $urandom;
    if (pick < 60) len = $urandom_range(12);
    else if (pick < 68) len = $urandom_range(125, 100);
    else if (pick < 84) len = $urandom_range(140);
    else len = $urandom_range(40);
    fq.push_back(8'($urandom_range(255)));
    if (pick < 68) begin
      fq.push_back({msk, 7'(len)});
    end else if (pick < 84) begin
      fq.push_back({msk, LenExt16});
      fq.push_back(len[15:8]);
      fq.push_back(len[7:0]);
    end else begin
      // set the reserved top bit at random
      fq.push_back({msk, LenExt64});
      fq.push_back({1'($urandom_range(1)), 7'd0});
      repeat (5) fq.push_back(8'h00);
      fq.push_back(len[15:8]);
      fq.push_back(len[7:0]);
    end
    if (msk) begin
      fq.push_back(key[31:24]);
      fq.push_back(key[23:16]);
      fq.push_back(key[15:8]);
      fq.push_back(key[7:0]);
    end
    repeat (len) fq.push_back(8'($urandom_range(255)));
    foreach (fq[i]) begin
      send_byte(fq[i], 1'b0, '0);
      phase_bytes++;
    end
  endtask

  initial begin
    dir_rows.push_back(plain_row(8'h89));
    dir_rows.push_back(checked_row(8'h00, KIND_HEADER, 1'b1, 4'h9, 1'b0, 63'd0, 8'h00, 1'b1));
    dir_rows.push_back(plain_row(8'h82));
    dir_rows.push_back(plain_row(8'h7F));
    dir_rows.push_back(plain_row(8'h80));
    repeat (6) dir_rows.push_back(plain_row(8'h00));
    dir_rows.push_back(checked_row(8'h01, KIND_HEADER, 1'b1, 4'h2, 1'b0, 63'd1, 8'h00, 1'b0));
    dir_rows.push_back(checked_row(8'hFF, KIND_PAYLOAD, 1'b1, 4'h2, 1'b0, 63'd1, 8'hFF,
                                   1'b1));
    dir_rows.push_back(plain_row(8'h0F));
    dir_rows.push_back(plain_row(8'hFE));
    dir_rows.push_back(plain_row(8'h00));
    dir_rows.push_back(plain_row(8'h01));
    dir_rows.push_back(plain_row(8'hA5));
    dir_rows.push_back(plain_row(8'h5A));
    dir_rows.push_back(plain_row(8'h00));
    dir_rows.push_back(checked_row(8'hFF, KIND_HEADER, 1'b0, 4'hF, 1'b1, 63'd1, 8'h00, 1'b0));
    dir_rows.push_back(plain_row(8'hA5));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < 3; p++) begin
      send_idle   = send_idle_plan[p];
      recv_idle   = recv_idle_plan[p];
      phase_bytes = 0;
      if (p == 0) begin
        foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);
      end
      while (phase_bytes < PhaseBytes) send_random_frame();
      // hold the sender until the results have drained
      in_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clk);
      @(negedge clk);
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("websocket_frame_deframer test passed");
    end else begin
      $display("websocket_frame_deframer test failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/wsfd_pkg.sv
sv/wsfd_parser.sv
sv/websocket_frame_deframer.sv
sv/wsfd_checker.sv
test/websocket_frame_deframer_tb.sv
